### rtl/otsu_pkg.sv
// Package for the Otsu threshold block: item types, command codes and shared constants.
// Used by every module of the block but otsu_mul; depends on nothing.
`timescale 1ns / 1ps

package otsu_pkg;

    localparam int LEVELS = 256;
    localparam int LEVEL_BITS = 8;
    localparam int COUNT_BITS_DEFAULT = 21;

    localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic [7:0] threshold;
        logic       is_threshold_report;
    } res_item_t;

    typedef struct packed {
        logic       is_acc;
        logic       is_cmp;
        logic       is_app;
        logic       is_clr;
        logic [7:0] pixel;
    } op_t;

endpackage

### rtl/otsu_threshold_binarize.sv
// Top level of the Otsu threshold block: front queue and back sequencer.
// Depends on otsu_pkg, otsu_front and otsu_back.
//
//   channel  valid      stall      payload
//   input    pix_valid  pix_stall  pix_item (command, pixel)
//   result   res_valid  res_stall  res_item (pixel_out, threshold, is_threshold_report)
//
// Accumulate passes through S_IDLE and S_ACC_WR; apply and clear finish in S_IDLE.
// Compute walks all 256 levels through S_RD, S_CHK and S_NEXT; a level that is not
// skipped also runs six serial multiplies (one multiplier bit per cycle) in S_MUL.
// Reset empties the queue, the histogram, the totals and the threshold.
// A stalled result blocks only apply and compute items; a full queue raises pix_stall.
`timescale 1ns / 1ps

module otsu_threshold_binarize #(
    parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  otsu_pkg::pix_item_t pix_item,
    output logic                res_valid,
    input  logic                res_stall,
    output otsu_pkg::res_item_t res_item
);

    logic          head_valid;
    otsu_pkg::op_t head;
    logic          pop;

    otsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    otsu_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule

### rtl/otsu_front.sv
// Front part: accepts items, decodes the command and holds them in a two-entry queue.
// Depends on otsu_pkg.
`timescale 1ns / 1ps

module otsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  otsu_pkg::pix_item_t pix_item,
    output logic               head_valid,
    output otsu_pkg::op_t      head,
    input  logic               pop
);

    otsu_pkg::op_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          take;
    otsu_pkg::op_t decoded;

    always_comb
    begin
        decoded.is_acc = (pix_item.command == otsu_pkg::CMD_ACCUMULATE);
        decoded.is_cmp = (pix_item.command == otsu_pkg::CMD_COMPUTE);
        decoded.is_app = (pix_item.command == otsu_pkg::CMD_APPLY);
        decoded.is_clr = (pix_item.command == otsu_pkg::CMD_CLEAR);
        decoded.pixel = pix_item.pixel;
    end

    assign pix_stall = (count_reg == 2'd2);
    assign push = pix_valid && !pix_stall;
    assign head_valid = (count_reg != 2'd0);
    assign take = pop && head_valid;
    assign head = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, take};
        end
    end

endmodule

### rtl/otsu_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// Used by the back part for the exact score arithmetic; depends on nothing.
`timescale 1ns / 1ps

module otsu_mul #(
    parameter int AW = 100,
    parameter int BW = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] prod
);

    localparam int PW = AW + BW;

    logic [PW-1:0] acc_reg;
    logic [PW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic          busy_reg;

    assign busy = busy_reg;
    assign prod = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg <= PW'(a);
            b_reg <= b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (b_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

### rtl/otsu_back.sv
// Back part: histogram memory, totals, the threshold search sequencer and the result register.
// Depends on otsu_pkg and otsu_mul.
`timescale 1ns / 1ps

module otsu_back #(
    parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  otsu_pkg::op_t       head,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output otsu_pkg::res_item_t res_item
);

    localparam int CB = COUNT_BITS;
    localparam int WB = CB + 8;
    localparam int BW = 2 * CB + 8;
    localparam int AW = 2 * BW;
    localparam int PW = AW + BW;
    localparam int LB = otsu_pkg::LEVEL_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC_WR = 4'd1;
    localparam logic [3:0] S_RD = 4'd2;
    localparam logic [3:0] S_CHK = 4'd3;
    localparam logic [3:0] S_MUL = 4'd4;
    localparam logic [3:0] S_NEXT = 4'd5;

    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
    localparam logic [WB-1:0] WEIGHT_MAX = {WB{1'b1}};

    logic [CB-1:0] mem [otsu_pkg::LEVELS];
    logic [otsu_pkg::LEVELS-1:0] vld_reg, vld_next;
    logic [CB-1:0] rd_data_reg;
    logic          rd_vld_reg;
    logic [LB-1:0] rd_addr;
    logic          mem_we;
    logic [CB-1:0] wr_data;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    mstep_reg, mstep_next;
    logic [LB-1:0] k_reg, k_next;
    logic [LB-1:0] acc_addr_reg, acc_addr_next;
    logic [WB-1:0] w_reg, w_next;
    logic [WB-1:0] s_reg, s_next;
    logic [CB-1:0] n_reg, n_next;
    logic [WB-1:0] st_reg, st_next;
    logic [7:0]    thr_reg, thr_next;
    logic [BW-1:0] x_reg, x_next;
    logic [AW-1:0] num_reg, num_next;
    logic [BW-1:0] den_reg, den_next;
    logic [PW-1:0] lhs_reg, lhs_next;
    logic [AW-1:0] best_num_reg, best_num_next;
    logic [BW-1:0] best_den_reg, best_den_next;
    logic          out_valid_reg, out_valid_next;
    otsu_pkg::res_item_t out_item_reg, out_item_next;

    logic          mul_start;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          mul_busy;
    logic [PW-1:0] prod;
    logic          out_free;
    logic [CB-1:0] bin;
    logic [BW-1:0] y_val;
    logic [BW-1:0] diff;
    logic [WB:0]   wsum;

    otsu_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (prod)
    );

    assign out_free = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res_item = out_item_reg;
    assign bin = rd_vld_reg ? rd_data_reg : '0;
    assign y_val = prod[BW-1:0];
    assign diff = (x_reg >= y_val) ? (x_reg - y_val) : (y_val - x_reg);
    assign rd_addr = (state_reg == S_IDLE) ? (head.is_acc ? head.pixel : '0) : (k_reg + 1'b1);
    assign wr_data = (bin == COUNT_MAX) ? bin : (bin + 1'b1);
    assign wsum = {1'b0, st_reg} + (WB + 1)'(head.pixel);

    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        k_next = k_reg;
        acc_addr_next = acc_addr_reg;
        w_next = w_reg;
        s_next = s_reg;
        n_next = n_reg;
        st_next = st_reg;
        thr_next = thr_reg;
        x_next = x_reg;
        num_next = num_reg;
        den_next = den_reg;
        lhs_next = lhs_reg;
        best_num_next = best_num_reg;
        best_den_next = best_den_reg;
        vld_next = vld_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_item_next = out_item_reg;
        pop = 1'b0;
        mem_we = 1'b0;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.is_acc)
                    begin
                        pop = 1'b1;
                        acc_addr_next = head.pixel;
                        if (n_reg != COUNT_MAX)
                        begin
                            n_next = n_reg + 1'b1;
                        end
                        st_next = wsum[WB] ? WEIGHT_MAX : wsum[WB-1:0];
                        state_next = S_ACC_WR;
                    end
                    else if (head.is_cmp)
                    begin
                        pop = 1'b1;
                        k_next = '0;
                        w_next = '0;
                        s_next = '0;
                        best_num_next = '0;
                        best_den_next = BW'(1);
                        state_next = S_RD;
                    end
                    else if (head.is_app)
                    begin
                        if (out_free)
                        begin
                            pop = 1'b1;
                            out_valid_next = 1'b1;
                            out_item_next.pixel_out = (head.pixel > thr_reg) ? head.pixel : 8'd0;
                            out_item_next.threshold = thr_reg;
                            out_item_next.is_threshold_report = 1'b0;
                        end
                    end
                    else
                    begin
                        pop = 1'b1;
                        thr_next = '0;
                    end
                end
            end
            S_ACC_WR:
            begin
                mem_we = 1'b1;
                vld_next[acc_addr_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                w_next = w_reg + WB'(bin);
                s_next = s_reg + WB'(k_reg * bin);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((w_reg == '0) || (w_reg >= WB'(n_reg)))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    mul_start = 1'b1;
                    mul_a = AW'(st_reg);
                    mul_b = BW'(w_reg);
                    mstep_next = 3'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (!mul_busy)
                begin
                    mstep_next = mstep_reg + 1'b1;
                    mul_start = 1'b1;
                    case (mstep_reg)
                        3'd0:
                        begin
                            x_next = prod[BW-1:0];
                            mul_a = AW'(n_reg);
                            mul_b = BW'(s_reg);
                        end
                        3'd1:
                        begin
                            mul_a = AW'(diff);
                            mul_b = diff;
                        end
                        3'd2:
                        begin
                            num_next = prod[AW-1:0];
                            mul_a = AW'(w_reg);
                            mul_b = BW'(n_reg) - BW'(w_reg);
                        end
                        3'd3:
                        begin
                            den_next = prod[BW-1:0];
                            mul_a = num_reg;
                            mul_b = best_den_reg;
                        end
                        3'd4:
                        begin
                            lhs_next = prod;
                            mul_a = best_num_reg;
                            mul_b = den_reg;
                        end
                        default:
                        begin
                            mul_start = 1'b0;
                            if (lhs_reg > prod)
                            begin
                                best_num_next = num_reg;
                                best_den_next = den_reg;
                                thr_next = k_reg;
                            end
                            state_next = S_NEXT;
                        end
                    endcase
                end
            end
            S_NEXT:
            begin
                if (k_reg != {LB{1'b1}})
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (out_free)
                begin
                    vld_next = '0;
                    n_next = '0;
                    st_next = '0;
                    out_valid_next = 1'b1;
                    out_item_next.pixel_out = 8'd0;
                    out_item_next.threshold = thr_reg;
                    out_item_next.is_threshold_report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[acc_addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
        mstep_reg <= mstep_next;
        k_reg <= k_next;
        acc_addr_reg <= acc_addr_next;
        w_reg <= w_next;
        s_reg <= s_next;
        x_reg <= x_next;
        num_reg <= num_next;
        den_reg <= den_next;
        lhs_reg <= lhs_next;
        best_num_reg <= best_num_next;
        best_den_reg <= best_den_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg <= '0;
            n_reg <= '0;
            st_reg <= '0;
            thr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            n_reg <= n_next;
            st_reg <= st_next;
            thr_reg <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/otsu_checker.sv
// Port checker for the Otsu threshold block and its bind to the top level.
// Depends on otsu_pkg and otsu_threshold_binarize.
`timescale 1ns / 1ps

module otsu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input otsu_pkg::res_item_t res_item
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("Stalled result item changed.");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.is_threshold_report |-> res_item.pixel_out == 8'd0)
        else $error("Threshold report carries a pixel.");

    a_apply_above: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.is_threshold_report |->
        (res_item.pixel_out == 8'd0) || (res_item.pixel_out > res_item.threshold))
        else $error("Passed pixel is not above the threshold.");

endmodule

bind otsu_threshold_binarize otsu_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

### tb/otsu_threshold_binarize_tb.sv
// Testbench for otsu_threshold_binarize: random and directed pixel streams, with a
// scoreboard that predicts the histogram, the threshold search and the binarized pixels.
// Depends on otsu_pkg and the block's RTL.
`timescale 1ns / 1ps

class otsu_scoreboard;
    localparam longint COUNT_MAX = (64'd1 << 21) - 1;
    localparam longint WEIGHT_MAX = (64'd1 << 29) - 1;

    longint unsigned bin_count[256];
    longint unsigned pixel_count;
    longint unsigned pixel_sum;
    logic [7:0] thr;
    otsu_pkg::res_item_t awaited[$];
    int errors;

    function new();
        foreach (bin_count[i]) bin_count[i] = 0;
        pixel_count = 0;
        pixel_sum = 0;
        thr = '0;
        errors = 0;
    endfunction

    function void find_threshold();
        logic [63:0] w, s, n, st;
        logic [255:0] best_num, best_den, x, y, num, den, lhs, rhs;
        n = pixel_count;
        st = pixel_sum;
        w = 0;
        s = 0;
        best_num = 0;
        best_den = 1;
        for (int k = 0; k < 256; k++)
        begin
            w = w + bin_count[k];
            s = s + k * bin_count[k];
            if (w != 0 && w < n)
            begin
                x = st * w;
                y = n * s;
                num = (x >= y) ? x - y : y - x;
                num = num * num;
                den = w * (n - w);
                lhs = num * best_den;
                rhs = best_num * den;
                if (lhs > rhs)
                begin
                    best_num = num;
                    best_den = den;
                    thr = 8'(k);
                end
            end
        end
        foreach (bin_count[i]) bin_count[i] = 0;
        pixel_count = 0;
        pixel_sum = 0;
    endfunction

    function void note_input(otsu_pkg::pix_item_t item);
        otsu_pkg::res_item_t r;
        case (item.command)
            otsu_pkg::CMD_ACCUMULATE:
            begin
                if (bin_count[item.pixel] < COUNT_MAX) bin_count[item.pixel]++;
                if (pixel_count < COUNT_MAX) pixel_count++;
                pixel_sum = pixel_sum + item.pixel;
                if (pixel_sum > WEIGHT_MAX) pixel_sum = WEIGHT_MAX;
            end
            otsu_pkg::CMD_COMPUTE:
            begin
                find_threshold();
                r.pixel_out = 8'd0;
                r.threshold = thr;
                r.is_threshold_report = 1'b1;
                awaited.insert(awaited.size(), r);
            end
            otsu_pkg::CMD_APPLY:
            begin
                r.pixel_out = (item.pixel > thr) ? item.pixel : 8'd0;
                r.threshold = thr;
                r.is_threshold_report = 1'b0;
                awaited.insert(awaited.size(), r);
            end
            default: thr = '0;
        endcase
    endfunction

    function void check_result(otsu_pkg::res_item_t got);
        otsu_pkg::res_item_t want;
        if (awaited.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (got.pixel_out !== want.pixel_out)
        begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel_out,
                     got.pixel_out);
            errors++;
        end
        if (got.threshold !== want.threshold)
        begin
            $display("%0t: threshold expected %0d actual %0d", $time, want.threshold,
                     got.threshold);
            errors++;
        end
        if (got.is_threshold_report !== want.is_threshold_report)
        begin
            $display("%0t: is_threshold_report expected %0b actual %0b", $time,
                     want.is_threshold_report, got.is_threshold_report);
            errors++;
        end
    endfunction
endclass

module otsu_threshold_binarize_tb;

    logic                clk;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_stall;
    otsu_pkg::pix_item_t pix_item;
    logic                res_valid;
    logic                res_stall;
    otsu_pkg::res_item_t res_item;

    otsu_scoreboard sb;
    int sent;
    int cycle_count;

    otsu_threshold_binarize i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_item(pix_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall) sb.note_input(pix_item);
        if (rst_n && res_valid && !res_stall) sb.check_result(res_item);
    end

    initial
    begin
        res_stall = 1'b0;
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= 3000 && cycle_count < 4000)
                res_stall <= 1'b1;
            else if (cycle_count >= 8000 && cycle_count < 30000)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(99) < 14);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] pix);
        int gap;
        if (sent > 0 && !(sent >= 300 && sent < 600) && $urandom_range(99) < 14)
        begin
            pix_valid <= 1'b0;
            gap = int'($urandom_range(1, 4));
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item.command <= cmd;
        pix_item.pixel <= pix;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_image();
        int count, span, base, wide;
        wide = ($urandom_range(9) == 0) ? 1 : 0;
        span = (wide != 0) ? 255 : int'($urandom_range(0, 15));
        base = int'($urandom_range(0, 255 - span));
        count = int'($urandom_range(1, 40));
        for (int i = 0; i < count; i++)
        begin
            send_item(otsu_pkg::CMD_ACCUMULATE, 8'(base + int'($urandom_range(0, span))));
            if ($urandom_range(19) == 0) send_item(otsu_pkg::CMD_APPLY, 8'($urandom_range(255)));
        end
        send_item(otsu_pkg::CMD_COMPUTE, 8'($urandom_range(255)));
        count = int'($urandom_range(1, 6));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(7) == 0)
                send_item(otsu_pkg::CMD_CLEAR, 8'($urandom_range(255)));
            send_item(otsu_pkg::CMD_APPLY, 8'($urandom_range(255)));
        end
    endtask

    task automatic send_noise();
        int count;
        logic [1:0] cmd;
        count = int'($urandom_range(1, 4));
        for (int i = 0; i < count; i++)
        begin
            cmd = 2'($urandom_range(3));
            if (cmd == otsu_pkg::CMD_COMPUTE && $urandom_range(7) != 0)
                cmd = otsu_pkg::CMD_APPLY;
            send_item(cmd, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty histogram: no level scores, so the threshold stays at zero.
        send_item(otsu_pkg::CMD_COMPUTE, 8'd0);
        send_item(otsu_pkg::CMD_APPLY, 8'd0);
        send_item(otsu_pkg::CMD_APPLY, 8'd255);
        // A single level only: every split is degenerate.
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd77);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd77);
        send_item(otsu_pkg::CMD_COMPUTE, 8'd0);
        // Extremes of the pixel range.
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd0);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd255);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd255);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd0);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd128);
        send_item(otsu_pkg::CMD_COMPUTE, 8'd255);
        send_item(otsu_pkg::CMD_APPLY, 8'd0);
        send_item(otsu_pkg::CMD_APPLY, 8'd1);
        send_item(otsu_pkg::CMD_APPLY, 8'd255);
        send_item(otsu_pkg::CMD_APPLY, 8'd170);
        // The threshold survives a compute with no positive score.
        send_item(otsu_pkg::CMD_COMPUTE, 8'd0);
        send_item(otsu_pkg::CMD_APPLY, 8'd100);
        send_item(otsu_pkg::CMD_CLEAR, 8'd255);
        send_item(otsu_pkg::CMD_APPLY, 8'd1);
        send_item(otsu_pkg::CMD_APPLY, 8'd0);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd10);
        send_item(otsu_pkg::CMD_CLEAR, 8'd0);
        send_item(otsu_pkg::CMD_ACCUMULATE, 8'd20);
        send_item(otsu_pkg::CMD_COMPUTE, 8'd0);

        while (sent < 1750)
        begin
            if ($urandom_range(99) < 85)
                send_image();
            else
                send_noise();
        end
        pix_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
